@@ sv/vector_normalize_top_assert.svh @@
// Assertion macros for the vector normalize RTL.
`ifndef VECTOR_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR_NORMALIZE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vn_pkg.sv @@
// Shared widths, constants and item types for the vector normalize block.
package vn_pkg;

    localparam int COMP_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int GUARD_BITS = 8;
    localparam int OUT_BITS   = 16;

    localparam int SUM_BITS  = 2 * COMP_BITS;
    localparam int RAD_BITS  = SUM_BITS + 2 * GUARD_BITS;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int MAG_BITS  = COMP_BITS;
    localparam int NUM_BITS  = MAG_BITS + FRAC_BITS + GUARD_BITS;
    localparam int QUO_BITS  = FRAC_BITS + 1;

    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [COMP_BITS-1:0] x;
        logic signed [COMP_BITS-1:0] y;
        logic signed [COMP_BITS-1:0] z;
        logic [SUM_BITS-1:0]         sum;
        logic                        zero;
    } t_vec_item;

endpackage

@@ sv/vn_front.sv @@
// Front end: accepts vectors, squares and sums components, flags zero vectors.
module vn_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [vn_pkg::COMP_BITS-1:0] i_comp_x,
    input  logic signed [vn_pkg::COMP_BITS-1:0] i_comp_y,
    input  logic signed [vn_pkg::COMP_BITS-1:0] i_comp_z,
    input  logic                              i_q_full,
    output logic                              o_push,
    output vn_pkg::t_vec_item                 o_item
);
    import vn_pkg::*;

    logic                        w_en;
    logic                        r_v1, r_v2;
    logic signed [COMP_BITS-1:0] r_cx, r_cy, r_cz;
    logic signed [SUM_BITS-1:0]  n_sx, n_sy, n_sz;
    logic [SUM_BITS-1:0]         r_sx, r_sy, r_sz;
    logic [SUM_BITS-1:0]         n_sum;
    t_vec_item                   r_item;

    assign w_en    = !(r_v2 && i_q_full);
    assign o_ready = w_en;
    assign o_push  = r_v2 && w_en;
    assign o_item  = r_item;

    assign n_sx  = i_comp_x * i_comp_x;
    assign n_sy  = i_comp_y * i_comp_y;
    assign n_sz  = i_comp_z * i_comp_z;
    assign n_sum = SUM_BITS'(r_sx + r_sy + r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx        <= i_comp_x;
            r_cy        <= i_comp_y;
            r_cz        <= i_comp_z;
            r_sx        <= SUM_BITS'(n_sx);
            r_sy        <= SUM_BITS'(n_sy);
            r_sz        <= SUM_BITS'(n_sz);
            r_item.x    <= r_cx;
            r_item.y    <= r_cy;
            r_item.z    <= r_cz;
            r_item.sum  <= n_sum;
            r_item.zero <= (n_sum == '0);
        end
    end

endmodule

@@ sv/vn_fifo.sv @@
// Short item queue between the front end and the back end.
module vn_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vn_pkg::t_vec_item i_item,
    input  logic              i_pop,
    output vn_pkg::t_vec_item o_item,
    output logic              o_full,
    output logic              o_empty
);
    import vn_pkg::*;

    t_vec_item       r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

@@ sv/vn_sqrt.sv @@
// Pipelined integer square root of the guarded sum, one root bit per stage.
module vn_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  vn_pkg::t_vec_item             i_item,
    output logic                          o_valid,
    output vn_pkg::t_vec_item             o_item,
    output logic [vn_pkg::ROOT_BITS-1:0]  o_root
);
    import vn_pkg::*;

    logic                 r_v    [ROOT_BITS+1];
    t_vec_item            r_it   [ROOT_BITS+1];
    logic [REM_BITS-1:0]  r_rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_it[0]   <= i_item;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        localparam int P = ROOT_BITS - 1 - k;
        logic [RAD_BITS-1:0]  w_rad;
        logic [REM_BITS-1:0]  w_sh, w_trial;
        logic [REM_BITS-1:0]  n_rem;
        logic [ROOT_BITS-1:0] n_root;

        always_comb begin
            w_rad   = {r_it[k].sum, {(2*GUARD_BITS){1'b0}}};
            w_sh    = {r_rem[k][REM_BITS-3:0], w_rad[2*P+1 -: 2]};
            w_trial = {r_root[k], 2'b01};
            if (w_sh >= w_trial) begin
                n_rem  = w_sh - w_trial;
                n_root = {r_root[k][ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {r_root[k][ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_it[k+1]   <= r_it[k];
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
            end
        end
    end

    assign o_valid = r_v[ROOT_BITS];
    assign o_item  = r_it[ROOT_BITS];
    assign o_root  = r_root[ROOT_BITS];

endmodule

@@ sv/vn_div.sv @@
// Pipelined three-lane restoring divide, saturation and sign, output register.
module vn_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  vn_pkg::t_vec_item                   i_item,
    input  logic [vn_pkg::ROOT_BITS-1:0]        i_root,
    output logic                                o_valid,
    output logic signed [vn_pkg::OUT_BITS-1:0]  o_unit_x,
    output logic signed [vn_pkg::OUT_BITS-1:0]  o_unit_y,
    output logic signed [vn_pkg::OUT_BITS-1:0]  o_unit_z,
    output logic                                o_zero_input
);
    import vn_pkg::*;

    localparam logic [QUO_BITS-1:0] ONE = QUO_BITS'(1) << FRAC_BITS;

    logic                 r_v    [QUO_BITS+1];
    logic                 r_zero [QUO_BITS+1];
    logic [ROOT_BITS-1:0] r_den  [QUO_BITS+1];
    logic [2:0]           r_neg  [QUO_BITS+1];
    logic [NUM_BITS-1:0]  r_rem  [QUO_BITS+1][3];
    logic [QUO_BITS-1:0]  r_quo  [QUO_BITS+1][3];

    logic signed [COMP_BITS-1:0] w_c   [3];
    logic [MAG_BITS-1:0]         w_mag [3];
    logic [QUO_BITS-1:0]         w_sat [3];
    logic [OUT_BITS-1:0]         n_out [3];

    logic                        r_ov, r_oz;
    logic [OUT_BITS-1:0]         r_out [3];

    assign w_c[0] = i_item.x;
    assign w_c[1] = i_item.y;
    assign w_c[2] = i_item.z;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = w_c[l][COMP_BITS-1] ? MAG_BITS'(~w_c[l] + 1'b1)
                                           : MAG_BITS'(w_c[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_zero[0] <= i_item.zero;
            r_den[0]  <= i_root;
            for (int l = 0; l < 3; l++) begin
                r_neg[0][l] <= w_c[l][COMP_BITS-1];
                r_rem[0][l] <= {w_mag[l], {(FRAC_BITS+GUARD_BITS){1'b0}}};
                r_quo[0][l] <= '0;
            end
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        localparam int J = QUO_BITS - 1 - k;
        logic [NUM_BITS:0]   w_d;
        logic [NUM_BITS-1:0] n_rem [3];
        logic [QUO_BITS-1:0] n_quo [3];

        always_comb begin
            w_d = (NUM_BITS+1)'(r_den[k]) << J;
            for (int l = 0; l < 3; l++) begin
                n_rem[l] = r_rem[k][l];
                n_quo[l] = r_quo[k][l];
                if ((NUM_BITS+1)'(r_rem[k][l]) >= w_d) begin
                    n_rem[l]    = NUM_BITS'((NUM_BITS+1)'(r_rem[k][l]) - w_d);
                    n_quo[l][J] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_zero[k+1] <= r_zero[k];
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                for (int l = 0; l < 3; l++) begin
                    r_rem[k+1][l] <= n_rem[l];
                    r_quo[k+1][l] <= n_quo[l];
                end
            end
        end
    end

    // clamp the small rounding overshoot, then apply the sign
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sat[l] = (r_quo[QUO_BITS][l] > ONE) ? ONE : r_quo[QUO_BITS][l];
            if (r_zero[QUO_BITS])
                n_out[l] = '0;
            else if (r_neg[QUO_BITS][l])
                n_out[l] = OUT_BITS'(~OUT_BITS'(w_sat[l]) + 1'b1);
            else
                n_out[l] = OUT_BITS'(w_sat[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_ov <= r_v[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oz <= r_zero[QUO_BITS];
            for (int l = 0; l < 3; l++) r_out[l] <= n_out[l];
        end
    end

    assign o_valid      = r_ov;
    assign o_zero_input = r_oz;
    assign o_unit_x     = r_out[0];
    assign o_unit_y     = r_out[1];
    assign o_unit_z     = r_out[2];

endmodule

@@ sv/vector_normalize_top.sv @@
// Top level of the 3D vector normalizer: front end, queue, root and divide pipeline.
//
//  channel | direction | handshake           | fields
//  --------+-----------+---------------------+-------------------------------------
//  vector  | in        | i_valid / o_ready   | i_comp_x, i_comp_y, i_comp_z (s16)
//  unit    | out       | o_valid / i_ready   | o_unit_x/y/z (s16 Q2.14), o_zero_input
//
// One vector is accepted per cycle and one result leaves per cycle when the sink keeps up.
// The path runs through 2 front stages, the queue slot, 25 root stages (an input register
// and 24 stages of one root bit each), 16 divide stages (an input register and 15 stages
// of one quotient bit each, three lanes) and the output register.
// Synchronous active-low reset clears valid bits and queue pointers; payload is not reset.
// A stall at the output freezes the whole back end; the 4-entry queue then absorbs the
// front stages before o_ready drops.
module vector_normalize_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [vn_pkg::COMP_BITS-1:0] i_comp_x,
    input  logic signed [vn_pkg::COMP_BITS-1:0] i_comp_y,
    input  logic signed [vn_pkg::COMP_BITS-1:0] i_comp_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [vn_pkg::OUT_BITS-1:0]  o_unit_x,
    output logic signed [vn_pkg::OUT_BITS-1:0]  o_unit_y,
    output logic signed [vn_pkg::OUT_BITS-1:0]  o_unit_z,
    output logic                                o_zero_input
);
    import vn_pkg::*;

    `include "vector_normalize_top_assert.svh"

    logic                 w_push, w_pop, w_full, w_empty, w_adv;
    t_vec_item            w_fr_item, w_q_item, w_sq_item;
    logic                 w_sq_valid;
    logic [ROOT_BITS-1:0] w_root;

    // back end moves whenever the output register is free or being drained
    assign w_adv = !o_valid || i_ready;
    assign w_pop = w_adv && !w_empty;

    vn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_comp_x (i_comp_x),
        .i_comp_y (i_comp_y),
        .i_comp_z (i_comp_z),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_fr_item)
    );

    vn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fr_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_pop),
        .i_item  (w_q_item),
        .o_valid (w_sq_valid),
        .o_item  (w_sq_item),
        .o_root  (w_root)
    );

    vn_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (w_sq_valid),
        .i_item       (w_sq_item),
        .i_root       (w_root),
        .o_valid      (o_valid),
        .o_unit_x     (o_unit_x),
        .o_unit_y     (o_unit_y),
        .o_unit_z     (o_unit_z),
        .o_zero_input (o_zero_input)
    );

    `VN_ASSERT_NOW(a_no_overflow, w_push, !w_full, "push into full queue")
    `VN_ASSERT_NOW(a_zero_out, o_valid && o_zero_input,
        (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0), "zero vector nonzero output")
    `VN_ASSERT_NOW(a_range, o_valid,
        (o_unit_x <= 16'sd16384) && (o_unit_x >= -16'sd16384) &&
        (o_unit_y <= 16'sd16384) && (o_unit_y >= -16'sd16384) &&
        (o_unit_z <= 16'sd16384) && (o_unit_z >= -16'sd16384), "unit component out of range")

endmodule
